>>> rtl/ogpd_pkg.sv
// ----------------------------------------------------------------------------
// Ogg Opus page demux package
// Shared result type, result kind codes and the fixed byte patterns used when
// parsing Ogg pages and Opus header packets.
// ----------------------------------------------------------------------------
package ogpd_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_AUDIO     = 2'd0,
    KIND_END_CLEAN = 2'd1,
    KIND_END_CUT   = 2'd2
  } kind_e;

  // One result item as it is queued for the output.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic        last;
    logic [31:0] rate;
  } res_t;

  // Page header: the segment count is the byte at offset 26 of a 27-byte header.
  localparam logic [4:0]  HDR_SEG_IDX   = 5'd26;
  localparam logic [4:0]  HDR_AFTER_CAP = 5'd4;
  // Lacing value that continues a packet into the next segment.
  localparam logic [7:0]  SEG_RUN       = 8'd255;
  // Minimum packet sizes for the identification and comment headers.
  localparam logic [15:0] HEAD_MIN_LEN  = 16'd19;
  localparam logic [15:0] TAGS_MIN_LEN  = 16'd8;
  // Rate in force until an identification header is taken.
  localparam logic [31:0] DEFAULT_RATE  = 32'd16000;
  // Entries in the result queue.
  localparam int unsigned QUEUE_DEPTH   = 4;

  // Capture pattern "OggS" and the two header signatures.
  localparam logic [7:0] CAP_PAT  [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};
  localparam logic [7:0] HEAD_SIG [8] = '{8'h4F, 8'h70, 8'h75, 8'h73,
                                          8'h48, 8'h65, 8'h61, 8'h64};
  localparam logic [7:0] TAGS_SIG [8] = '{8'h4F, 8'h70, 8'h75, 8'h73,
                                          8'h54, 8'h61, 8'h67, 8'h73};

endpackage

>>> rtl/ogpd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ogpd_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 255,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ogpd_parser.sv
// ----------------------------------------------------------------------------
// Ogg page parser
// Walks sync, header, lacing and body phases one byte per item, keeps the
// packet length table in a RAM and produces audio and end results.
// ----------------------------------------------------------------------------
module ogpd_parser import ogpd_pkg::*; #(
  parameter int unsigned MAX_PACKETS = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_i,
  input  logic       end_i,
  output logic       audio_vld_o,
  output res_t       audio_res_o,
  output logic       end_vld_o,
  output res_t       end_res_o
);

  localparam int unsigned AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int unsigned FW = $clog2(MAX_PACKETS + 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(MAX_PACKETS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PACKETS - 1);

  typedef enum logic [1:0] {
    PH_SYNC   = 2'd0,
    PH_HEADER = 2'd1,
    PH_LACING = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CL_SKIP  = 2'd0,
    CL_HEAD  = 2'd1,
    CL_TAGS  = 2'd2,
    CL_AUDIO = 2'd3
  } class_e;

  // Class of a packet that is about to start.
  function automatic class_e classify(input logic [15:0] len, input logic head_seen,
                                      input logic tags_seen);
    class_e c;
    if (!head_seen) begin
      c = (len >= HEAD_MIN_LEN) ? CL_HEAD : CL_SKIP;
    end else if (!tags_seen) begin
      c = (len >= TAGS_MIN_LEN) ? CL_TAGS : CL_SKIP;
    end else begin
      c = CL_AUDIO;
    end
    return c;
  endfunction

  phase_e        phase_q, phase_d;
  class_e        class_q, class_d;
  logic [1:0]    sync_q, sync_d;
  logic [4:0]    hdr_q, hdr_d;
  logic [7:0]    seg_cnt_q, seg_cnt_d;
  logic [7:0]    seg_rd_q, seg_rd_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] rd_q, rd_d;
  logic [15:0]   acc_q, acc_d;
  logic [15:0]   remain_q, remain_d;
  logic [4:0]    idx_q, idx_d;
  logic          sig_q, sig_d;
  logic          head_q, head_d;
  logic          tags_q, tags_d;
  logic [31:0]   rate_q, rate_d;
  logic [31:0]   shift_q, shift_d;
  logic [15:0]   first_len_q, first_len_d;
  logic [15:0]   last_len_q, last_len_d;
  logic          byp_vld_q;
  logic [15:0]   byp_data_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;
  logic [FW:0]   rd_p1;
  logic [15:0]   next_len;
  logic [15:0]   acc_sum;
  logic          seg_last;
  logic [15:0]   remain_n;
  logic [FW-1:0] rd_n;
  logic          start_en;
  logic [15:0]   start_len;

  assign acc_sum  = acc_q + {8'd0, data_i};
  assign seg_last = (seg_rd_q + 8'd1) == seg_cnt_q;
  assign remain_n = remain_q - 16'd1;
  assign rd_n     = rd_q + FW'(1);
  // Length of the next packet, taken from the write port when it was just written.
  assign next_len = byp_vld_q ? byp_data_q : rdata;

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_d     = phase_q;
    class_d     = class_q;
    sync_d      = sync_q;
    hdr_d       = hdr_q;
    seg_cnt_d   = seg_cnt_q;
    seg_rd_d    = seg_rd_q;
    fill_d      = fill_q;
    rd_d        = rd_q;
    acc_d       = acc_q;
    remain_d    = remain_q;
    idx_d       = idx_q;
    sig_d       = sig_q;
    head_d      = head_q;
    tags_d      = tags_q;
    rate_d      = rate_q;
    shift_d     = shift_q;
    first_len_d = first_len_q;
    last_len_d  = last_len_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = acc_sum;
    start_en    = 1'b0;
    start_len   = next_len;
    audio_vld_o = 1'b0;
    audio_res_o = '{kind: KIND_AUDIO, payload: data_i, last: (remain_n == 16'd0),
                    rate: rate_q};
    end_vld_o   = 1'b0;
    end_res_o   = '{kind: KIND_END_CLEAN, payload: 8'd0, last: 1'b0, rate: rate_q};

    if (fire_i) begin
      case (phase_q)
        PH_SYNC: begin
          if (data_i == CAP_PAT[sync_q]) begin
            if (sync_q == 2'd3) begin
              sync_d  = 2'd0;
              hdr_d   = HDR_AFTER_CAP;
              phase_d = PH_HEADER;
            end else begin
              sync_d = sync_q + 2'd1;
            end
          end else begin
            sync_d = (data_i == CAP_PAT[0]) ? 2'd1 : 2'd0;
          end
        end
        PH_HEADER: begin
          if (hdr_q >= HDR_SEG_IDX) begin
            seg_cnt_d = data_i;
            seg_rd_d  = 8'd0;
            fill_d    = '0;
            rd_d      = '0;
            acc_d     = 16'd0;
            phase_d   = (data_i == 8'd0) ? PH_SYNC : PH_LACING;
          end else begin
            hdr_d = hdr_q + 5'd1;
          end
        end
        PH_LACING: begin
          seg_rd_d = seg_rd_q + 8'd1;
          acc_d    = (data_i != SEG_RUN || seg_last) ? 16'd0 : acc_sum;
          // A finished packet, or a run still open at the page end, is entered.
          if (acc_sum != 16'd0 && (data_i != SEG_RUN || seg_last)) begin
            we = 1'b1;
            if (fill_q < FILL_MAX) begin
              waddr  = fill_q[AW-1:0];
              fill_d = fill_q + FW'(1);
            end else begin
              waddr = LAST_ADDR;
              wdata = last_len_q + acc_sum;
            end
            last_len_d = wdata;
            if (waddr == '0) begin
              first_len_d = wdata;
            end
          end
          if (seg_last) begin
            if (fill_d == '0) begin
              phase_d = PH_SYNC;
            end else begin
              rd_d      = '0;
              phase_d   = PH_BODY;
              start_en  = 1'b1;
              start_len = first_len_d;
            end
          end
        end
        default: begin
          // Signature check and rate capture for header candidates.
          if (class_q == CL_HEAD) begin
            if (idx_q < 5'd8 && data_i != HEAD_SIG[idx_q[2:0]]) begin
              sig_d = 1'b0;
            end
            if (idx_q >= 5'd12 && idx_q < 5'd16) begin
              shift_d = shift_q | ({24'd0, data_i} << {idx_q[1:0], 3'b000});
            end
          end else if (class_q == CL_TAGS) begin
            if (idx_q < 5'd8 && data_i != TAGS_SIG[idx_q[2:0]]) begin
              sig_d = 1'b0;
            end
          end
          // The byte index only matters below 16, so it saturates there.
          idx_d       = (idx_q == 5'd16) ? idx_q : idx_q + 5'd1;
          remain_d    = remain_n;
          audio_vld_o = (class_q == CL_AUDIO);
          if (remain_n == 16'd0) begin
            if (class_q == CL_HEAD && sig_d) begin
              head_d = 1'b1;
              rate_d = shift_d;
            end else if (class_q == CL_TAGS && sig_d) begin
              tags_d = 1'b1;
            end
            rd_d = rd_n;
            if (rd_n >= fill_q) begin
              phase_d = PH_SYNC;
              sync_d  = 2'd0;
              class_d = CL_SKIP;
            end else begin
              start_en  = 1'b1;
              start_len = next_len;
            end
          end
        end
      endcase

      // Packet start.
      if (start_en) begin
        remain_d = start_len;
        idx_d    = 5'd0;
        sig_d    = 1'b1;
        shift_d  = 32'd0;
        class_d  = classify(start_len, head_d, tags_d);
      end

      // End of the data: report how it ended and return to the reset state.
      if (end_i) begin
        end_vld_o      = 1'b1;
        end_res_o.kind = (phase_d == PH_SYNC) ? KIND_END_CLEAN : KIND_END_CUT;
        end_res_o.rate = rate_d;
        phase_d   = PH_SYNC;
        class_d   = CL_SKIP;
        sync_d    = 2'd0;
        hdr_d     = 5'd0;
        seg_cnt_d = 8'd0;
        seg_rd_d  = 8'd0;
        fill_d    = '0;
        rd_d      = '0;
        acc_d     = 16'd0;
        remain_d  = 16'd0;
        idx_d     = 5'd0;
        sig_d     = 1'b0;
        head_d    = 1'b0;
        tags_d    = 1'b0;
        rate_d    = DEFAULT_RATE;
        shift_d   = 32'd0;
      end
    end
  end

  // The RAM reads the entry after the one the next state points to, or entry zero past the end.
  assign rd_p1 = {1'b0, rd_d} + (FW+1)'(1);
  assign raddr = (rd_p1 < (FW+1)'(MAX_PACKETS)) ? rd_p1[AW-1:0] : '0;

  ogpd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PACKETS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      class_q     <= CL_SKIP;
      sync_q      <= 2'd0;
      hdr_q       <= 5'd0;
      seg_cnt_q   <= 8'd0;
      seg_rd_q    <= 8'd0;
      fill_q      <= '0;
      rd_q        <= '0;
      acc_q       <= 16'd0;
      remain_q    <= 16'd0;
      idx_q       <= 5'd0;
      sig_q       <= 1'b0;
      head_q      <= 1'b0;
      tags_q      <= 1'b0;
      rate_q      <= DEFAULT_RATE;
      shift_q     <= 32'd0;
      first_len_q <= 16'd0;
      last_len_q  <= 16'd0;
      byp_vld_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      class_q     <= class_d;
      sync_q      <= sync_d;
      hdr_q       <= hdr_d;
      seg_cnt_q   <= seg_cnt_d;
      seg_rd_q    <= seg_rd_d;
      fill_q      <= fill_d;
      rd_q        <= rd_d;
      acc_q       <= acc_d;
      remain_q    <= remain_d;
      idx_q       <= idx_d;
      sig_q       <= sig_d;
      head_q      <= head_d;
      tags_q      <= tags_d;
      rate_q      <= rate_d;
      shift_q     <= shift_d;
      first_len_q <= first_len_d;
      last_len_q  <= last_len_d;
      byp_vld_q   <= we && (waddr == raddr);
    end
  end

  // Bypass data for a read that collides with a write.
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  // A page body always has at least one packet and a valid read pointer.
  a_body_has_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> (fill_q != '0 && rd_q < fill_q))
    else $error("body phase without a pending packet");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("packet table fill beyond its depth");

  a_lacing_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LACING |-> seg_cnt_q != 8'd0)
    else $error("lacing phase with no segments");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && end_i) |=> (phase_q == PH_SYNC && !head_q && rate_q == DEFAULT_RATE))
    else $error("state not cleared after the final byte");

endmodule

>>> rtl/ogpd_outq.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands one
// per cycle to the output channel while the channel is ready.
// ----------------------------------------------------------------------------
module ogpd_outq import ogpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  res_t res0_i,
  input  logic push1_i,
  input  res_t res1_i,
  output logic room_o,
  output logic valid_o,
  output res_t res_o,
  input  logic ready_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  res_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] slot1;
  logic          pop;

  assign valid_o = (count_q != '0);
  assign res_o   = slot_q[rd_q];
  assign pop     = valid_o && ready_i;
  // Room for the worst case of two results from one item.
  assign room_o  = (count_q <= CW'(QUEUE_DEPTH - 2));
  assign slot1   = push0_i ? wr_q + PW'(1) : wr_q;

  // Pointer and count update.
  always_comb begin
    wr_d    = wr_q + PW'(push0_i) + PW'(push1_i);
    rd_d    = rd_q + PW'(pop);
    count_d = count_q + CW'(push0_i) + CW'(push1_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      slot_q[wr_q] <= res0_i;
    end
    if (push1_i) begin
      slot_q[slot1] <= res1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push0_i || push1_i) |-> room_o)
    else $error("result pushed without room");

  a_double_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push0_i && push1_i && !pop) |=> count_q == $past(count_q) + CW'(2))
    else $error("double push lost a result");

endmodule

>>> rtl/ogg_opus_page_demux_unit.sv
// ----------------------------------------------------------------------------
// Ogg Opus page demultiplexer
// Takes an Ogg Opus stream one byte per item, finds pages, splits their bodies
// into packets, takes the sample rate from the identification header and
// sends out the bytes of every audio packet, plus an end result per stream.
//
//   Channel | Dir | tdata                                 | tuser       | tlast
//   s_axis  | in  | [7:0] data_byte                       | -           | stream_end
//   m_axis  | out | [7:0] payload_byte, [39:8] stream_rate| result_kind | packet_last
//
// One input item is taken per cycle while the result queue has room; each item
// passes an input register, the parser and the result queue on its way out.
// Packet lengths come from a RAM read one packet ahead, so no byte waits on it.
// Input stalls only when the four-entry result queue has fewer than two free
// slots. Reset is asynchronous, active low; no clearing pass follows it.
// ----------------------------------------------------------------------------
module ogg_opus_page_demux_unit import ogpd_pkg::*; #(
  parameter int unsigned MAX_PACKETS_PER_PAGE = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] stream_rate
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast    // packet_last
);

  logic       in_vld_q;
  logic [7:0] in_data_q;
  logic       in_end_q;
  logic       accept;
  logic       fire;
  logic       room;
  logic       audio_vld;
  logic       end_vld;
  res_t       audio_res;
  res_t       end_res;
  res_t       out_res;

  // The input register drains whenever the queue can take both results.
  assign fire          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Page and packet parsing.
  ogpd_parser #(
    .MAX_PACKETS (MAX_PACKETS_PER_PAGE)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_i      (in_data_q),
    .end_i       (in_end_q),
    .audio_vld_o (audio_vld),
    .audio_res_o (audio_res),
    .end_vld_o   (end_vld),
    .end_res_o   (end_res)
  );

  // Result queue in front of the output channel.
  ogpd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (audio_vld),
    .res0_i  (audio_res),
    .push1_i (end_vld),
    .res1_i  (end_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.rate, out_res.payload};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

>>> verif/ogpd_demux_checker.sv
// ----------------------------------------------------------------------------
// Ogg Opus page demux checker
// Watches both stream channels of the demux. Every byte taken at the input
// is run through a bit-accurate parser of its own, which queues the results
// it produces. Every result item taken at the output is compared field by
// field with the oldest queued result. Mismatches and stray results are
// counted; the count and the number of results still due go to the top.
// ----------------------------------------------------------------------------
module ogpd_demux_checker import ogpd_pkg::*; #(
  parameter int unsigned MAX_PKTS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // stream_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] stream_rate
  input  logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  input  logic        m_axis_tlast,   // packet_last
  output int          fail_count_o,
  output int          pending_o,
  output int          audio_count_o,
  output int          end_count_o
);

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_LACING, PH_BODY} parse_ph_e;
  typedef enum logic [1:0] {PK_SKIP, PK_HEAD, PK_TAGS, PK_AUDIO} pkt_class_e;

  // Parser state.
  parse_ph_e   parse_ph;
  logic [1:0]  cap_hits;
  logic [4:0]  hdr_cnt;
  logic [7:0]  seg_total;
  logic [7:0]  seg_seen;
  logic [15:0] len_tab [MAX_PKTS];
  logic [15:0] tab_fill;
  logic [15:0] tab_rd;
  logic [15:0] run_len;
  logic [15:0] bytes_left;
  logic [15:0] byte_pos;
  pkt_class_e  cls;
  logic        sig_good;
  logic        have_head;
  logic        have_tags;
  logic [31:0] cur_rate;
  logic [31:0] rate_acc;

  res_t expected_out_q [$];
  int   fail_total  = 0;
  int   audio_total = 0;
  int   end_total   = 0;

  assign fail_count_o  = fail_total;
  assign pending_o     = expected_out_q.size();
  assign audio_count_o = audio_total;
  assign end_count_o   = end_total;

  function automatic void reset_parser();
    parse_ph   = PH_HUNT;
    cap_hits   = '0;
    hdr_cnt    = '0;
    seg_total  = '0;
    seg_seen   = '0;
    tab_fill   = '0;
    tab_rd     = '0;
    run_len    = '0;
    bytes_left = '0;
    byte_pos   = '0;
    cls        = PK_SKIP;
    sig_good   = 1'b0;
    have_head  = 1'b0;
    have_tags  = 1'b0;
    cur_rate   = DEFAULT_RATE;
    rate_acc   = '0;
  endfunction

  // A full table folds any further length into its last entry.
  function automatic void store_length(input logic [15:0] len);
    if (tab_fill < MAX_PKTS) begin
      len_tab[tab_fill] = len;
      tab_fill++;
    end else begin
      len_tab[MAX_PKTS-1] = len_tab[MAX_PKTS-1] + len;
    end
  endfunction

  // Class of a packet depends on which header packets have been taken so far.
  function automatic void open_packet();
    logic [15:0] len;
    len        = (tab_rd < MAX_PKTS) ? len_tab[tab_rd] : 16'd0;
    bytes_left = len;
    byte_pos   = '0;
    sig_good   = 1'b1;
    rate_acc   = '0;
    if (!have_head) begin
      cls = (len >= HEAD_MIN_LEN) ? PK_HEAD : PK_SKIP;
    end else if (!have_tags) begin
      cls = (len >= TAGS_MIN_LEN) ? PK_TAGS : PK_SKIP;
    end else begin
      cls = PK_AUDIO;
    end
  endfunction

  // Advances the parser by one stream byte and queues the results it causes.
  function automatic void parse_stream_byte(input logic [7:0] b, input logic fin);
    res_t        r;
    logic [15:0] pos;
    case (parse_ph)
      PH_HUNT: begin
        if (b == CAP_PAT[cap_hits]) begin
          if (cap_hits == 2'd3) begin
            cap_hits = '0;
            hdr_cnt  = HDR_AFTER_CAP;
            parse_ph = PH_HEADER;
          end else begin
            cap_hits++;
          end
        end else begin
          cap_hits = (b == CAP_PAT[0]) ? 2'd1 : 2'd0;
        end
      end
      PH_HEADER: begin
        if (hdr_cnt >= HDR_SEG_IDX) begin
          seg_total = b;
          seg_seen  = '0;
          tab_fill  = '0;
          tab_rd    = '0;
          run_len   = '0;
          parse_ph  = (b == 8'd0) ? PH_HUNT : PH_LACING;
        end else begin
          hdr_cnt++;
        end
      end
      PH_LACING: begin
        run_len = run_len + 16'(b);
        if (b != SEG_RUN) begin
          if (run_len != 0) store_length(run_len);
          run_len = '0;
        end
        seg_seen++;
        // An open run of 255 closes its packet at the end of the table.
        if (seg_seen == seg_total) begin
          if (run_len != 0) store_length(run_len);
          run_len = '0;
          if (tab_fill == 0) begin
            parse_ph = PH_HUNT;
          end else begin
            tab_rd   = '0;
            parse_ph = PH_BODY;
            open_packet();
          end
        end
      end
      default: begin
        pos = byte_pos;
        if (cls == PK_HEAD) begin
          if (pos < 8 && b != HEAD_SIG[pos[2:0]]) sig_good = 1'b0;
          if (pos >= 12 && pos < 16) rate_acc |= 32'(b) << (8 * (pos - 12));
        end else if (cls == PK_TAGS) begin
          if (pos < 8 && b != TAGS_SIG[pos[2:0]]) sig_good = 1'b0;
        end
        byte_pos   = pos + 16'd1;
        bytes_left = bytes_left - 16'd1;
        if (cls == PK_AUDIO) begin
          r.kind    = KIND_AUDIO;
          r.payload = b;
          r.last    = (bytes_left == 0);
          r.rate    = cur_rate;
          expected_out_q.push_back(r);
        end
        if (bytes_left == 0) begin
          if (cls == PK_HEAD && sig_good) begin
            have_head = 1'b1;
            cur_rate  = rate_acc;
          end else if (cls == PK_TAGS && sig_good) begin
            have_tags = 1'b1;
          end
          tab_rd++;
          if (tab_rd >= tab_fill) begin
            parse_ph = PH_HUNT;
            cap_hits = '0;
            cls      = PK_SKIP;
          end else begin
            open_packet();
          end
        end
      end
    endcase

    // The end of a stream reports where it fell and starts afresh.
    if (fin) begin
      r.kind    = (parse_ph == PH_HUNT) ? KIND_END_CLEAN : KIND_END_CUT;
      r.payload = '0;
      r.last    = 1'b0;
      r.rate    = cur_rate;
      expected_out_q.push_back(r);
      reset_parser();
    end
  endfunction

  // Predict on every input item, then compare every output item.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      reset_parser();
      expected_out_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_stream_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          $error("result item with nothing due: kind %0d payload %02h",
                 m_axis_tuser, m_axis_tdata[7:0]);
          fail_total++;
        end else begin
          want = expected_out_q.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("result_kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
            fail_total++;
          end
          if (m_axis_tdata[7:0] !== want.payload) begin
            $error("payload_byte mismatch: expected %02h, actual %02h",
                   want.payload, m_axis_tdata[7:0]);
            fail_total++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("packet_last mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
            fail_total++;
          end
          if (m_axis_tdata[39:8] !== want.rate) begin
            $error("stream_rate mismatch: expected %0d, actual %0d",
                   want.rate, m_axis_tdata[39:8]);
            fail_total++;
          end
          if (want.kind == KIND_AUDIO) begin
            audio_total++;
          end else begin
            end_total++;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_ogg_opus_page_demux_unit.sv
// ----------------------------------------------------------------------------
// Ogg Opus page demux testbench
// Builds Ogg streams byte by byte: directed streams for empty pages, rejected
// and accepted header packets, a full 255-packet page and cut streams, then
// random streams that are mostly well formed, with noise and truncation mixed
// in. Both sides idle at random; the checker beside the block does the
// prediction and comparison, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_ogg_opus_page_demux_unit import ogpd_pkg::*; ();

  localparam int RANDOM_BYTES     = 110;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT      = 10000;

  typedef enum logic [1:0] {BUILD_HEAD, BUILD_TAGS, BUILD_AUDIO} pkt_build_e;

  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } ogg_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int audio_count;
  int end_count;

  ogg_byte_t  ogg_bytes_q [$];
  int         page_lens   [$];
  logic [7:0] page_body   [$];

  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  bit long_hold_req = 1'b0;
  int bytes_sent    = 0;
  int streams_built = 0;

  ogg_opus_page_demux_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ogpd_demux_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .audio_count_o (audio_count),
    .end_count_o   (end_count)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("Timeout: the run did not complete in time.");
    $display("tb: failure");
    $finish;
  end

  // Output side: a random stall before each item, plus one long hold on request.
  initial begin : sink
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        stall         = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        stall = ($urandom_range(0, 99) < snk_idle_pct) ? $urandom_range(1, 19) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  task automatic push_ogg_byte(input logic [7:0] v);
    ogg_byte_t it;
    it.data = v;
    it.fin  = 1'b0;
    ogg_bytes_q.push_back(it);
  endtask

  // Drops the given number of trailing bytes and marks the new last byte.
  task automatic end_stream(input int drop);
    ogg_byte_t it;
    repeat (drop) void'(ogg_bytes_q.pop_back());
    it     = ogg_bytes_q.pop_back();
    it.fin = 1'b1;
    ogg_bytes_q.push_back(it);
    streams_built++;
  endtask

  // Adds one packet to the page under construction.
  task automatic add_packet(input pkt_build_e what, input int len, input logic [31:0] rate,
                            input bit spoil);
    logic [7:0] v;
    int         bad_at;
    bad_at = $urandom_range(0, 7);
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom);
      if (what == BUILD_HEAD && i < 8) v = HEAD_SIG[i];
      if (what == BUILD_TAGS && i < 8) v = TAGS_SIG[i];
      if (what == BUILD_HEAD && i >= 12 && i < 16) v = rate[8*(i-12) +: 8];
      if (spoil && i == bad_at) v = ~v;
      page_body.push_back(v);
    end
    page_lens.push_back(len);
  endtask

  // Writes out the page: capture pattern, header, lacing table and body.
  // With open_tail, a last packet that is a multiple of 255 ends on its run.
  task automatic emit_page(input bit open_tail);
    int lace [$];
    int rest;
    for (int k = 0; k < 4; k++) push_ogg_byte(CAP_PAT[k]);
    repeat (22) push_ogg_byte(8'($urandom));
    foreach (page_lens[k]) begin
      rest = page_lens[k];
      while (rest >= 255) begin
        lace.push_back(255);
        rest -= 255;
      end
      if (!(open_tail && k == page_lens.size() - 1 && rest == 0 && page_lens[k] > 0))
        lace.push_back(rest);
    end
    push_ogg_byte(8'(lace.size()));
    foreach (lace[k]) push_ogg_byte(8'(lace[k]));
    foreach (page_body[k]) push_ogg_byte(page_body[k]);
    page_lens.delete();
    page_body.delete();
  endtask

  // Offers every queued byte, each after a random gap.
  task automatic drive_bytes();
    ogg_byte_t it;
    int        gap;
    while (ogg_bytes_q.size() > 0) begin
      it  = ogg_bytes_q.pop_front();
      gap = ($urandom_range(0, 99) < src_idle_pct) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.data;
      s_axis_tlast  <= it.fin;
      do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
      @(negedge clk_i);
      bytes_sent++;
    end
  endtask

  // Stops offering until every result due has come out.
  task automatic hold_sender();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int rand_bytes;
    int mark;
    int drop;
    int len;
    int tags_mode;
    int waited;
    rand_bytes    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Stream ends while hunting for a page and inside a page header.
    push_ogg_byte(CAP_PAT[0]);
    push_ogg_byte(CAP_PAT[1]);
    end_stream(0);
    for (int k = 0; k < 4; k++) push_ogg_byte(CAP_PAT[k]);
    repeat (3) push_ogg_byte(8'($urandom));
    end_stream(0);
    drive_bytes();

    // Empty pages, a stray capture byte, then rejected and accepted header
    // packets, tags and audio sharing a page, and an open 255 run at page end.
    src_idle_pct = 30;
    snk_idle_pct = 30;
    emit_page(1'b0);
    add_packet(BUILD_AUDIO, 0, 32'd0, 1'b0);
    add_packet(BUILD_AUDIO, 0, 32'd0, 1'b0);
    emit_page(1'b0);
    push_ogg_byte(CAP_PAT[0]);
    add_packet(BUILD_HEAD, 19, 32'd48000, 1'b1);
    add_packet(BUILD_HEAD, 18, 32'd96000, 1'b0);
    add_packet(BUILD_HEAD, 19, 32'd0, 1'b0);
    emit_page(1'b0);
    add_packet(BUILD_TAGS, 8, 32'd0, 1'b1);
    add_packet(BUILD_TAGS, 7, 32'd0, 1'b0);
    add_packet(BUILD_TAGS, 8, 32'd0, 1'b0);
    add_packet(BUILD_AUDIO, 3, 32'd0, 1'b0);
    emit_page(1'b0);
    add_packet(BUILD_AUDIO, 1, 32'd0, 1'b0);
    add_packet(BUILD_AUDIO, 0, 32'd0, 1'b0);
    add_packet(BUILD_AUDIO, 2, 32'd0, 1'b0);
    add_packet(BUILD_AUDIO, 255, 32'd0, 1'b0);
    emit_page(1'b1);
    end_stream(0);
    drive_bytes();
    hold_sender();

    // Page with 255 one-byte packets, then an audio page cut inside its body.
    // The sink holds off for a long stretch so the block has to stall input.
    src_idle_pct = 0;
    snk_idle_pct = 10;
    add_packet(BUILD_HEAD, 19, 32'hFFFF_FFFF, 1'b0);
    add_packet(BUILD_TAGS, 8, 32'd0, 1'b0);
    emit_page(1'b0);
    repeat (255) add_packet(BUILD_AUDIO, 1, 32'd0, 1'b0);
    emit_page(1'b0);
    add_packet(BUILD_AUDIO, 60, 32'd0, 1'b0);
    emit_page(1'b0);
    end_stream(30);
    long_hold_req = 1'b1;
    drive_bytes();
    hold_sender();

    // Stream cut inside the identification packet; the rate stays at default.
    add_packet(BUILD_HEAD, 24, $urandom, 1'b0);
    emit_page(1'b0);
    end_stream(10);
    drive_bytes();
    hold_sender();

    // Random streams: mostly well formed, some noise, some cut short.
    while (rand_bytes < RANDOM_BYTES) begin
      src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      snk_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 40)) begin
          if ($urandom_range(0, 2) == 0) begin
            push_ogg_byte(CAP_PAT[$urandom_range(0, 3)]);
          end else begin
            push_ogg_byte(8'($urandom));
          end
        end
        end_stream(0);
      end else begin
        repeat ($urandom_range(0, 4)) push_ogg_byte(8'($urandom));
        // A header candidate that must be passed over.
        if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(8, 24);
          add_packet(BUILD_HEAD, len, $urandom, len >= 19);
          emit_page(1'b0);
        end
        add_packet(BUILD_HEAD, $urandom_range(19, 28), $urandom, 1'b0);
        tags_mode = $urandom_range(0, 7);
        if (tags_mode >= 1 && tags_mode <= 3)
          add_packet(BUILD_TAGS, $urandom_range(8, 16), 32'd0, 1'b0);
        emit_page(1'b0);
        if (tags_mode > 3) begin
          add_packet(BUILD_TAGS, $urandom_range(8, 16), 32'd0, 1'b0);
          emit_page(1'b0);
        end
        mark = ogg_bytes_q.size();
        repeat ($urandom_range(1, 3)) begin
          mark = ogg_bytes_q.size();
          if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) push_ogg_byte(8'($urandom));
          repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 19))
              0, 1:    len = 0;
              2:       len = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(256, 300);
              default: len = $urandom_range(1, 24);
            endcase
            add_packet(BUILD_AUDIO, len, 32'd0, 1'b0);
          end
          emit_page($urandom_range(0, 1));
        end
        if ($urandom_range(0, 3) == 0) begin
          drop = ogg_bytes_q.size() - mark - 1;
          if (drop > 60) drop = 60;
          end_stream($urandom_range(1, drop));
        end else begin
          end_stream(0);
        end
      end
      rand_bytes += ogg_bytes_q.size();
      drive_bytes();
      if ($urandom_range(0, 3) == 0) hold_sender();
    end

    // Let every result drain, then allow for the pipeline.
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending != 0) $error("%0d result items never arrived", pending);
    repeat (8) @(negedge clk_i);

    $display("Covered %0d streams in %0d input bytes: empty and full pages, header rejects,",
             streams_built, bytes_sent);
    $display("open 255 runs and cut streams; checked %0d audio bytes and %0d stream ends.",
             audio_count, end_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
